// ===== design/rebpk_pkg.sv =====
`default_nettype none
package rebpk_pkg;

  localparam int WordBits   = 32;
  localparam int CoordBits  = 17;
  localparam int VbBits     = 6;
  localparam int GridMax    = 65536;

  typedef enum logic [1:0] {
    REG_NUM_ROWS   = 2'd0,
    REG_NUM_COLS   = 2'd1,
    REG_VALUE_BITS = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_idx_t;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // grid sizes and field widths, derived when a register is written
  typedef struct packed {
    logic [CoordBits-1:0] nr;
    logic [CoordBits-1:0] nc;
    logic [4:0]           rb;
    logic [4:0]           cb;
    logic [VbBits-1:0]    vb;
  } cfg_t;

  typedef struct packed {
    logic [WordBits-1:0] word1;
    logic [WordBits-1:0] word2;
    logic [1:0]          nwords;
    logic [WordBits-1:0] packed_cnt;
    logic [WordBits-1:0] clipped_cnt;
  } res_t;

  function automatic logic [CoordBits-1:0] grid_clamp(input logic [CoordBits-1:0] n);
    grid_clamp = (n > CoordBits'(GridMax)) ? CoordBits'(GridMax) : n;
  endfunction

  // ceil(log2(n)) for n >= 1: bit length of n-1
  function automatic logic [4:0] index_bits(input logic [CoordBits-1:0] n);
    logic [CoordBits-1:0] m;
    logic [4:0]           b;
    m = n - CoordBits'(1);
    b = 5'd0;
    for (int i = 0; i < CoordBits; i++) begin
      if (m[i]) begin
        b = 5'(i + 1);
      end
    end
    index_bits = b;
  endfunction

endpackage
`default_nettype wire

// ===== design/raster_entry_bit_packer_unit.sv =====
`default_nettype none
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tdata {value, col, row}, tuser kind
// out_      out  out_tvalid/out_tready  tdata {clipped, accepted, word}, tuser word_valid,
//                                       tlast last
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// one item per cycle unless output stalls; results go via the input and output registers
// an entry that completes two words holds the input register
// while the output stage shows both words
// synchronous active-low reset empties the bit buffer and clears both counters
// the output register decouples the sides: a new item is taken while a result waits
module raster_entry_bit_packer_unit
  import rebpk_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [71:0]          in_tdata,   // row[16:0], col[33:17], value[65:34], zero pad
  input  wire logic                 in_tuser,   // kind
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [3*WordBits-1:0]     out_tdata,  // word[31:0], accepted_count[63:32],
                                                // clipped_count[95:64]
  output logic                      out_tlast,
  output logic                      out_tuser,  // word_valid
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CoordBits-1:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  rebpk_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rebpk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_row    (in_tdata[16:0]),
    .in_col    (in_tdata[33:17]),
    .in_value  (in_tdata[65:34]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rebpk_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // a non-final result always carries a word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("first of two results has no word");

  // result without a word shows zero in the word field
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("empty result carries a nonzero word");

  // an empty output stage never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // counters only move forward from one result to the next
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) ##1 out_tvalid |->
      out_tdata[63:32] >= $past(out_tdata[63:32]) &&
      out_tdata[95:64] >= $past(out_tdata[95:64]))
    else $error("counter went backwards");

endmodule
`default_nettype wire

// ===== design/rebpk_cfg.sv =====
`default_nettype none
module rebpk_cfg
  import rebpk_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CoordBits-1:0] cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic [CoordBits-1:0] grid_n;
  logic [VbBits-1:0]    vb_raw;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign grid_n    = grid_clamp(cfg_data);
  assign vb_raw    = cfg_data[VbBits-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_NUM_ROWS: begin
          cfg_nxt.nr = grid_n;
          cfg_nxt.rb = index_bits(grid_n);
        end
        REG_NUM_COLS: begin
          cfg_nxt.nc = grid_n;
          cfg_nxt.cb = index_bits(grid_n);
        end
        REG_VALUE_BITS: begin
          cfg_nxt.vb = (vb_raw > VbBits'(WordBits)) ? VbBits'(WordBits) : vb_raw;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nr <= CoordBits'(1);
      cfg_r.nc <= CoordBits'(1);
      cfg_r.rb <= 5'd0;
      cfg_r.cb <= 5'd0;
      cfg_r.vb <= VbBits'(WordBits);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/rebpk_core.sv =====
`default_nettype none
module rebpk_core
  import rebpk_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  cfg_t                      cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_kind,
  input  wire logic [CoordBits-1:0] in_row,
  input  wire logic [CoordBits-1:0] in_col,
  input  wire logic [WordBits-1:0]  in_value,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res
);

  logic                 in_valid_r;
  logic                 kind_r;
  logic [CoordBits-1:0] row_r, col_r;
  logic [WordBits-1:0]  value_r;

  // pending bits are kept left-aligned, unused low bits zero
  logic [WordBits-1:0]  buf_r, buf_nxt;
  logic [4:0]           used_r, used_nxt;
  logic [WordBits-1:0]  packed_r, packed_nxt;
  logic [WordBits-1:0]  clipped_r, clipped_nxt;

  logic                 advance;
  logic                 in_grid;
  logic [6:0]           n_bits;
  logic [6:0]           total;
  logic [WordBits-1:0]  val_mask;
  logic [63:0]          row_l, col_l, val_l, entry_l;
  logic [95:0]          window;

  assign advance   = in_valid_r && res_ready;
  assign in_ready  = !in_valid_r || res_ready;
  assign res_valid = in_valid_r;

  assign in_grid = !row_r[CoordBits-1] && !col_r[CoordBits-1] &&
                   (row_r < cfg.nr) && (col_r < cfg.nc);
  assign n_bits  = {2'b00, cfg.rb} + {2'b00, cfg.cb} + {1'b0, cfg.vb};
  assign total   = {2'b00, used_r} + n_bits;

  assign val_mask = (cfg.vb >= VbBits'(WordBits)) ? {WordBits{1'b1}} :
                    ((WordBits'(1) << cfg.vb) - WordBits'(1));
  // a shift by 64 clears the field, which is what a zero-width field needs
  assign row_l   = {48'b0, row_r[15:0]} << (7'd64 - {2'b00, cfg.rb});
  assign col_l   = {48'b0, col_r[15:0]} << (7'd64 - {2'b00, cfg.rb} - {2'b00, cfg.cb});
  assign val_l   = {32'b0, value_r & val_mask} << (7'd64 - n_bits);
  assign entry_l = row_l | col_l | val_l;
  assign window  = {buf_r, 64'b0} | ({entry_l, 32'b0} >> used_r);

  always_comb begin
    buf_nxt     = buf_r;
    used_nxt    = used_r;
    packed_nxt  = packed_r;
    clipped_nxt = clipped_r;
    res.word1   = '0;
    res.word2   = '0;
    res.nwords  = 2'd0;
    if (kind_r == KIND_FLUSH) begin
      if (used_r != 5'd0) begin
        res.word1  = buf_r;
        res.nwords = 2'd1;
      end
      buf_nxt  = '0;
      used_nxt = 5'd0;
    end else if (!in_grid) begin
      if (clipped_r != {WordBits{1'b1}}) begin
        clipped_nxt = clipped_r + WordBits'(1);
      end
    end else begin
      if (packed_r != {WordBits{1'b1}}) begin
        packed_nxt = packed_r + WordBits'(1);
      end
      if (total >= 7'd64) begin
        res.word1  = window[95:64];
        res.word2  = window[63:32];
        res.nwords = 2'd2;
        buf_nxt    = window[31:0];
        used_nxt   = 5'(total - 7'd64);
      end else if (total >= 7'd32) begin
        res.word1  = window[95:64];
        res.nwords = 2'd1;
        buf_nxt    = window[63:32];
        used_nxt   = 5'(total - 7'd32);
      end else begin
        buf_nxt  = window[95:64];
        used_nxt = total[4:0];
      end
    end
    res.packed_cnt  = packed_nxt;
    res.clipped_cnt = clipped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      buf_r      <= '0;
      used_r     <= 5'd0;
      packed_r   <= '0;
      clipped_r  <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        buf_r     <= buf_nxt;
        used_r    <= used_nxt;
        packed_r  <= packed_nxt;
        clipped_r <= clipped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r  <= in_kind;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
    end
  end

endmodule
`default_nettype wire

// ===== design/rebpk_out.sv =====
`default_nettype none
module rebpk_out
  import rebpk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  res_valid,
  output logic                       res_ready,
  input  res_t                       res,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [3*WordBits-1:0]      out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);

  logic res_valid_r;
  res_t res_r;
  logic phase_r;   // second word of a two-word item is on the port
  logic done;

  assign out_tvalid = res_valid_r;
  assign out_tlast  = phase_r || (res_r.nwords != 2'd2);
  assign out_tuser  = phase_r || (res_r.nwords != 2'd0);
  assign out_tdata  = {res_r.clipped_cnt, res_r.packed_cnt,
                       phase_r ? res_r.word2 : res_r.word1};
  assign done       = out_tready && out_tlast;
  assign res_ready  = !res_valid_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid_r <= res_valid;
        phase_r     <= 1'b0;
      end else if (out_tready) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb
  import rebpk_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [31:0] word;
    logic        word_valid;
    logic        last;
    logic [31:0] n_packed;
    logic [31:0] n_clipped;
  } word_result_t;

  // bit-accurate packer copy plus the queue of words still owed by the block
  class packed_word_board;
    logic [16:0]    rows;
    logic [16:0]    cols;
    logic [5:0]     vbits;
    logic [31:0]    buf_bits;
    int unsigned    free;
    logic [31:0]    n_packed;
    logic [31:0]    n_clipped;
    word_result_t   words_due[$];
    int             errors;

    function new();
      rows = 17'd1;
      cols = 17'd1;
      vbits = 6'd32;
      buf_bits = '0;
      free = 32;
      n_packed = '0;
      n_clipped = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [16:0] d);
      case (idx)
        REG_NUM_ROWS:   rows = d;
        REG_NUM_COLS:   cols = d;
        REG_VALUE_BITS: vbits = d[5:0];
        default: ;
      endcase
    endfunction

    function logic [16:0] clamp(logic [16:0] n);
      return (n > 17'd65536) ? 17'd65536 : n;
    endfunction

    function int unsigned width_of(logic [16:0] n);
      logic [16:0] m;
      int unsigned b;
      m = n - 17'd1;
      b = 0;
      while (m != 0) begin
        b++;
        m = m >> 1;
      end
      return b;
    endfunction

    function bit append(int unsigned n, logic [31:0] v, output logic [31:0] w);
      logic [63:0] vm;
      logic [63:0] acc;
      int unsigned used;
      used = 32 - free;
      vm = (n >= 32) ? {32'b0, v} : ({32'b0, v} & ((64'd1 << n) - 64'd1));
      acc = ({32'b0, buf_bits} << n) | vm;
      used += n;
      w = '0;
      if (used >= 32) begin
        used -= 32;
        w = 32'(acc >> used);
        buf_bits = 32'(acc & ((64'd1 << used) - 64'd1));
        free = 32 - used;
        return 1'b1;
      end
      buf_bits = acc[31:0];
      free = 32 - used;
      return 1'b0;
    endfunction

    function void pack_entry(logic kind, logic [16:0] row, logic [16:0] col,
                             logic [31:0] value);
      logic [31:0]  words[3];
      logic [31:0]  w;
      logic [16:0]  nr;
      logic [16:0]  nc;
      logic [63:0]  aligned;
      int unsigned  used;
      int unsigned  vb;
      int           nw;
      word_result_t r;
      nw = 0;
      if (kind == KIND_FLUSH) begin
        used = 32 - free;
        if (used > 0 && used < 32) begin
          aligned = {32'b0, buf_bits} << (32 - used);
          words[nw] = aligned[31:0];
          nw++;
        end
        buf_bits = '0;
        free = 32;
      end else begin
        nr = clamp(rows);
        nc = clamp(cols);
        if (row[16] || col[16] || row >= nr || col >= nc) begin
          if (n_clipped != 32'hFFFF_FFFF) n_clipped++;
        end else begin
          vb = (vbits > 6'd32) ? 32 : int'(vbits);
          if (append(width_of(nr), {15'b0, row}, w)) begin
            words[nw] = w;
            nw++;
          end
          if (append(width_of(nc), {15'b0, col}, w)) begin
            words[nw] = w;
            nw++;
          end
          if (append(vb, value, w)) begin
            words[nw] = w;
            nw++;
          end
          if (n_packed != 32'hFFFF_FFFF) n_packed++;
        end
      end
      r.n_packed = n_packed;
      r.n_clipped = n_clipped;
      if (nw == 0) begin
        r.word = '0;
        r.word_valid = 1'b0;
        r.last = 1'b1;
        words_due.push_back(r);
      end else begin
        if (nw > 2) nw = 2;
        for (int k = 0; k < nw; k++) begin
          r.word = words[k];
          r.word_valid = 1'b1;
          r.last = (k == nw - 1);
          words_due.push_back(r);
        end
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(word_result_t got);
      word_result_t want;
      if (words_due.size() == 0) begin
        report("unexpected item", got.word, '0);
      end else begin
        want = words_due.pop_front();
        if (got.word !== want.word) report("word", got.word, want.word);
        if (got.word_valid !== want.word_valid)
          report("word_valid", 32'(got.word_valid), 32'(want.word_valid));
        if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
        if (got.n_packed !== want.n_packed)
          report("accepted_count", got.n_packed, want.n_packed);
        if (got.n_clipped !== want.n_clipped)
          report("clipped_count", got.n_clipped, want.n_clipped);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  packed_word_board board;
  bit sender_gaps_on;
  bit sink_stalls_on;
  bit hold_pending;
  int quiet_cycles;

  raster_entry_bit_packer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sink side: random stall bursts, plus one long hold-off on request
  initial begin : sink_proc
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (sink_stalls_on && $urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 16);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    word_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.word = out_tdata[31:0];
      got.word_valid = out_tuser;
      got.last = out_tlast;
      got.n_packed = out_tdata[63:32];
      got.n_clipped = out_tdata[95:64];
      board.check_word(got);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [16:0] row, logic [16:0] col,
                           logic [31:0] value);
    int n;
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, value, col, row};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    board.pack_entry(kind, row, col, value);
  endtask

  task automatic entry(logic [16:0] row, logic [16:0] col, logic [31:0] value);
    send_item(KIND_ENTRY, row, col, value);
  endtask

  task automatic flush_buf();
    send_item(KIND_FLUSH, 17'($urandom), 17'($urandom), $urandom);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [16:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain all owed words, then reprogram the grid
  task automatic configure(logic [16:0] rows, logic [16:0] cols, logic [16:0] vb);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(REG_NUM_ROWS, rows);
    cfg_write(REG_NUM_COLS, cols);
    cfg_write(REG_VALUE_BITS, vb);
  endtask

  function automatic logic [16:0] pick_grid();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd2;
      3: return 17'd65536;
      4: return 17'($urandom_range(65537, 131071));
      5: return 17'($urandom_range(3, 300));
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic [16:0] pick_vbits();
    logic [16:0] upper;
    logic [5:0]  vb;
    upper = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'd0;
    case ($urandom_range(0, 6))
      0: vb = 6'd0;
      1: vb = 6'd32;
      2: vb = 6'($urandom_range(33, 63));
      3: vb = 6'd1;
      default: vb = 6'($urandom_range(1, 31));
    endcase
    return {upper[16:6], vb};
  endfunction

  task automatic random_item();
    logic [16:0] nr;
    logic [16:0] nc;
    logic [16:0] row;
    logic [16:0] col;
    logic [31:0] value;
    if ($urandom_range(0, 9) == 0) begin
      flush_buf();
    end else begin
      nr = board.clamp(board.rows);
      nc = board.clamp(board.cols);
      // mostly in-grid coordinates, the rest random and often clipped
      if (nr != 0 && $urandom_range(0, 4) != 0) row = 17'($urandom_range(0, int'(nr) - 1));
      else row = 17'($urandom);
      if (nc != 0 && $urandom_range(0, 4) != 0) col = 17'($urandom_range(0, int'(nc) - 1));
      else col = 17'($urandom);
      case ($urandom_range(0, 5))
        0: value = 32'h0;
        1: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      entry(row, col, value);
    end
  endtask

  initial begin : main
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_ENTRY;
    cfg_valid = 1'b0;
    cfg_index = REG_NUM_ROWS;
    cfg_data = '0;
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    hold_pending = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset grid is 1x1 with full 32-bit values
    entry(17'd0, 17'd0, 32'hFFFF_FFFF);
    entry(17'd0, 17'd0, 32'h0);
    entry(17'd1, 17'd0, 32'h1234_5678);
    entry(17'd0, 17'd1, 32'h1234_5678);
    entry(17'h1FFFF, 17'd0, 32'h0);
    entry(17'd0, 17'h10000, 32'h0);
    flush_buf();

    // widest grid: one entry spans two words
    configure(17'd65536, 17'd65536, 17'd32);
    entry(17'd65535, 17'd65535, 32'hFFFF_FFFF);
    entry(17'd0, 17'd0, 32'hA5A5_A5A5);
    flush_buf();

    // oversize rows act as 65536, partial word then flush
    configure(17'h1FFFF, 17'd3, 17'd5);
    entry(17'd65535, 17'd2, 32'hFFFF_FFFF);
    entry(17'd1, 17'd1, 32'hFFFF_FFFF);
    flush_buf();
    flush_buf();

    // empty grid clips everything, zero-width values
    configure(17'd0, 17'd5, 17'd0);
    entry(17'd0, 17'd0, 32'hFFFF_FFFF);
    entry(17'd0, 17'd4, 32'h0);

    // oversize value width acts as 32, single-column grid
    configure(17'd2, 17'd1, 17'd63);
    entry(17'd1, 17'd0, 32'hFFFF_FFFF);
    entry(17'd0, 17'd0, 32'h8000_0001);
    flush_buf();

    for (int ph = 0; ph < 11; ph++) begin
      sender_gaps_on = (ph < 9);
      sink_stalls_on = (ph < 9);
      if (ph == 0) configure(17'd65536, 17'd65536, 17'd32);
      else if (ph == 1) configure(17'd1, 17'd1, 17'd1);
      else configure(pick_grid(), pick_grid(), pick_vbits());
      if (ph == 3) begin
        hold_pending = 1'b1;
        sender_gaps_on = 1'b0;
      end
      repeat (50) random_item();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== raster_entry_bit_packer_unit.f =====
design/rebpk_pkg.sv
design/rebpk_cfg.sv
design/rebpk_core.sv
design/rebpk_out.sv
design/raster_entry_bit_packer_unit.sv
tb/tb.sv
